// File: hw/rtl/assembly_source_tokenizer_assert.svh
// Assertion macros used by the tokenizer checker.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASMTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASMTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/asmtok_pkg.sv
// Shared types, constants and helper functions of the assembly source tokenizer.
package asmtok_pkg;

  localparam int OFFSET_BITS   = 20;
  localparam int POSITION_BITS = 16;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0]   off_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  // Byte codes the tokenizer cares about.
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_RETURN     = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  typedef enum logic [3:0] {
    CLS_NEWLINE,
    CLS_BLANK,
    CLS_SEMI,
    CLS_VSPACE,
    CLS_COMMA,
    CLS_COLON,
    CLS_HASH,
    CLS_DOLLAR,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_UNDERSCORE,
    CLS_MINUS,
    CLS_OTHER
  } byte_cls_e;

  typedef enum logic [3:0] {
    KIND_NEWLINE    = 4'd0,
    KIND_SPACE      = 4'd1,
    KIND_PREPROCESS = 4'd2,
    KIND_COMMA      = 4'd3,
    KIND_COLON      = 4'd4,
    KIND_ID         = 4'd5,
    KIND_STRING     = 4'd6,
    KIND_NUMBER     = 4'd7,
    KIND_CHAR       = 4'd8
  } tok_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_NEWLINE_STRING = 3'd1,
    ERR_OPEN_STRING    = 3'd2,
    ERR_NEWLINE_CHAR   = 3'd3,
    ERR_OPEN_CHAR      = 3'd4,
    ERR_BAD_ID         = 3'd5,
    ERR_MINUS          = 3'd6,
    ERR_UNKNOWN_BYTE   = 3'd7
  } err_code_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } src_item_t;

  typedef struct packed {
    tok_kind_e token_kind;
    off_t      text_offset;
    off_t      text_length;
    pos_t      token_line;
    pos_t      token_column;
    err_code_e error_code;
    logic      last_result;
  } tok_item_t;

  // One classified byte as it waits between the front and the lexer.
  typedef struct packed {
    byte_cls_e cls;
    logic      eos;
  } cls_entry_t;

  function automatic off_t off_sat_inc(off_t v);
    return (v == '1) ? v : v + off_t'(1);
  endfunction

  function automatic pos_t pos_sat_inc(pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  // Column plus length, the length cut to the column width first.
  function automatic pos_t pos_sat_add(pos_t a, off_t b);
    logic [POSITION_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, POSITION_BITS'(b)};
    return sum[POSITION_BITS] ? '1 : sum[POSITION_BITS-1:0];
  endfunction

  function automatic tok_item_t make_tok(tok_kind_e kind, off_t off, off_t len,
                                         pos_t line, pos_t col, err_code_e err);
    tok_item_t t;
    t.token_kind   = kind;
    t.text_offset  = off;
    t.text_length  = len;
    t.token_line   = line;
    t.token_column = col;
    t.error_code   = err;
    t.last_result  = 1'b0;
    return t;
  endfunction

endpackage

// File: hw/rtl/asmtok_front.sv
// Input front: takes source bytes and sorts each into a byte class for the queue.
module asmtok_front (
  input  logic                   in_valid_i,
  input  asmtok_pkg::src_item_t  in_data_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output asmtok_pkg::cls_entry_t push_data_o,
  input  logic                   full_i
);
  import asmtok_pkg::*;

  function automatic byte_cls_e classify(logic [7:0] b);
    byte_cls_e c;
    if (b == CH_NEWLINE) c = CLS_NEWLINE;
    else if (b == CH_SPACE || b == CH_TAB) c = CLS_BLANK;
    else if (b == CH_SEMI) c = CLS_SEMI;
    else if (b == CH_VTAB || b == CH_FORMFEED || b == CH_RETURN) c = CLS_VSPACE;
    else if (b == CH_COMMA) c = CLS_COMMA;
    else if (b == CH_COLON) c = CLS_COLON;
    else if (b == CH_HASH) c = CLS_HASH;
    else if (b == CH_DOLLAR) c = CLS_DOLLAR;
    else if (b == CH_DQUOTE) c = CLS_DQUOTE;
    else if (b == CH_SQUOTE) c = CLS_SQUOTE;
    else if (b >= CH_ZERO && b <= CH_NINE) c = CLS_DIGIT;
    else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z))
      c = CLS_ALPHA;
    else if (b == CH_UNDERSCORE) c = CLS_UNDERSCORE;
    else if (b == CH_MINUS) c = CLS_MINUS;
    else c = CLS_OTHER;
    return c;
  endfunction

  // Hold off the source while the queue has no free slot.
  assign in_stall_o      = full_i;
  assign push_o          = in_valid_i & ~full_i;
  assign push_data_o.cls = classify(in_data_i.source_byte);
  assign push_data_o.eos = in_data_i.end_of_source;

endmodule

// File: hw/rtl/asmtok_fifo.sv
// Short queue of classified bytes between the front and the lexer.
module asmtok_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  asmtok_pkg::cls_entry_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   pop_valid_o,
  output asmtok_pkg::cls_entry_t pop_data_o
);
  import asmtok_pkg::*;

  cls_entry_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
  logic [QUEUE_CNT_BITS-1:0] count_q;
  logic                      do_push;
  logic                      do_pop;

  function automatic logic [QUEUE_PTR_BITS-1:0] ptr_next(logic [QUEUE_PTR_BITS-1:0] p);
    return (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_BITS'(1);
  endfunction

  assign full_o      = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/asmtok_lexer.sv
// Lexer back end: runs the token state machine and drives the token output register.
module asmtok_lexer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  asmtok_pkg::cls_entry_t q_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output asmtok_pkg::tok_item_t  out_data_o,
  input  logic                   out_stall_i
);
  import asmtok_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_PRE_START,
    M_ID_START,
    M_PRE_ID,
    M_ID,
    M_NUMBER,
    M_STRING,
    M_CHAR
  } lex_mode_e;

  lex_mode_e mode_q, mode_d;
  off_t      pos_q, pos_d;
  pos_t      line_q, line_d;
  pos_t      col_q, col_d;
  off_t      tso_q, tso_d;
  off_t      tlen_q, tlen_d;
  pos_t      tsl_q, tsl_d;
  pos_t      tsc_q, tsc_d;
  logic      halt_q, halt_d;

  tok_item_t out_q;
  logic      out_valid_q;
  tok_item_t pend_q;
  logic      pend_valid_q;

  tok_item_t res_a, res_b, res0, res1;
  logic      a_v, b_v, to_idle, slot_free;
  byte_cls_e cls;
  logic      eos;
  off_t      pos_inc;
  pos_t      col_inc, line_inc;

  function automatic tok_kind_e mode_kind(lex_mode_e m);
    tok_kind_e k;
    unique case (m)
      M_PRE_ID: k = KIND_PREPROCESS;
      M_NUMBER: k = KIND_NUMBER;
      M_STRING: k = KIND_STRING;
      M_CHAR:   k = KIND_CHAR;
      default:  k = KIND_ID;
    endcase
    return k;
  endfunction

  assign cls      = q_data_i.cls;
  assign eos      = q_data_i.eos;
  assign pos_inc  = off_sat_inc(pos_q);
  assign col_inc  = pos_sat_inc(col_q);
  assign line_inc = pos_sat_inc(line_q);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    line_d  = line_q;
    col_d   = col_q;
    tso_d   = tso_q;
    tlen_d  = tlen_q;
    tsl_d   = tsl_q;
    tsc_d   = tsc_q;
    halt_d  = halt_q;
    res_a   = '0;
    res_b   = '0;
    a_v     = 1'b0;
    b_v     = 1'b0;
    to_idle = 1'b0;

    if (!halt_q) begin
      unique case (mode_q) inside
        M_COMMENT: begin
          if (cls == CLS_NEWLINE) begin
            mode_d  = M_IDLE;
            to_idle = 1'b1;
          end else begin
            pos_d = pos_inc;
            col_d = col_inc;
          end
        end
        M_PRE_START, M_ID_START: begin
          if (cls == CLS_ALPHA) begin
            mode_d = (mode_q == M_PRE_START) ? M_PRE_ID : M_ID;
            tso_d  = pos_q;
            tlen_d = off_t'(1);
            tsl_d  = line_q;
            tsc_d  = col_q;
            pos_d  = pos_inc;
            col_d  = col_inc;
            if (eos) begin
              a_v    = 1'b1;
              res_a  = make_tok(mode_kind(mode_d), pos_q, off_t'(1), line_q, col_q, ERR_NONE);
              mode_d = M_IDLE;
            end
          end else begin
            a_v    = 1'b1;
            res_a  = make_tok(KIND_NEWLINE, pos_q, '0, line_q, col_q, ERR_BAD_ID);
            halt_d = 1'b1;
          end
        end
        M_PRE_ID, M_ID, M_NUMBER: begin
          if ((mode_q == M_NUMBER) ? (cls == CLS_DIGIT)
              : (cls == CLS_ALPHA || cls == CLS_DIGIT || cls == CLS_UNDERSCORE)) begin
            tlen_d = off_sat_inc(tlen_q);
            pos_d  = pos_inc;
            col_d  = col_inc;
            if (eos) begin
              a_v    = 1'b1;
              res_a  = make_tok(mode_kind(mode_q), tso_q, tlen_d, tsl_q, tsc_q, ERR_NONE);
              mode_d = M_IDLE;
            end
          end else begin
            a_v     = 1'b1;
            res_a   = make_tok(mode_kind(mode_q), tso_q, tlen_q, tsl_q, tsc_q, ERR_NONE);
            mode_d  = M_IDLE;
            to_idle = 1'b1;
          end
        end
        M_STRING, M_CHAR: begin
          if (cls == CLS_NEWLINE) begin
            a_v    = 1'b1;
            res_a  = make_tok(KIND_NEWLINE, pos_q, '0, tsl_q, pos_sat_add(tsc_q, tlen_q),
                              (mode_q == M_STRING) ? ERR_NEWLINE_STRING : ERR_NEWLINE_CHAR);
            halt_d = 1'b1;
          end else begin
            pos_d = pos_inc;
            col_d = col_inc;
            if (cls == ((mode_q == M_STRING) ? CLS_DQUOTE : CLS_SQUOTE)) begin
              a_v    = 1'b1;
              res_a  = make_tok(mode_kind(mode_q), tso_q, tlen_q, tsl_q, tsc_q, ERR_NONE);
              mode_d = M_IDLE;
            end else begin
              tlen_d = off_sat_inc(tlen_q);
              if (eos) begin
                a_v    = 1'b1;
                res_a  = make_tok(KIND_NEWLINE, pos_inc, '0, tsl_q, tsc_q,
                                  (mode_q == M_STRING) ? ERR_OPEN_STRING : ERR_OPEN_CHAR);
                halt_d = 1'b1;
              end
            end
          end
        end
        default: begin
          mode_d  = M_IDLE;
          to_idle = 1'b1;
        end
      endcase

      // Start-of-token decode; position counters have not moved yet on this path.
      if (to_idle) begin
        case (cls) inside
          CLS_NEWLINE: begin
            b_v    = 1'b1;
            res_b  = make_tok(KIND_NEWLINE, pos_q, '0, line_q, col_q, ERR_NONE);
            pos_d  = pos_inc;
            line_d = line_inc;
            col_d  = pos_t'(1);
          end
          CLS_BLANK: begin
            pos_d = pos_inc;
            col_d = col_inc;
          end
          CLS_SEMI: begin
            mode_d = M_COMMENT;
            pos_d  = pos_inc;
            col_d  = col_inc;
          end
          CLS_VSPACE, CLS_COMMA, CLS_COLON: begin
            b_v   = 1'b1;
            res_b = make_tok((cls == CLS_VSPACE) ? KIND_SPACE
                             : (cls == CLS_COMMA) ? KIND_COMMA : KIND_COLON,
                             pos_q, '0, line_q, col_q, ERR_NONE);
            pos_d = pos_inc;
            col_d = col_inc;
          end
          CLS_HASH, CLS_DOLLAR: begin
            pos_d  = pos_inc;
            col_d  = col_inc;
            mode_d = (cls == CLS_HASH) ? M_PRE_START : M_ID_START;
            if (eos) begin
              b_v    = 1'b1;
              res_b  = make_tok(KIND_NEWLINE, pos_inc, '0, line_q, col_inc, ERR_BAD_ID);
              halt_d = 1'b1;
            end
          end
          CLS_DQUOTE, CLS_SQUOTE: begin
            mode_d = (cls == CLS_DQUOTE) ? M_STRING : M_CHAR;
            tso_d  = pos_inc;
            tlen_d = '0;
            tsl_d  = line_q;
            tsc_d  = col_q;
            pos_d  = pos_inc;
            col_d  = col_inc;
            if (eos) begin
              b_v    = 1'b1;
              res_b  = make_tok(KIND_NEWLINE, pos_inc, '0, line_q, col_q,
                                (cls == CLS_DQUOTE) ? ERR_OPEN_STRING : ERR_OPEN_CHAR);
              halt_d = 1'b1;
            end
          end
          CLS_DIGIT, CLS_ALPHA: begin
            mode_d = (cls == CLS_DIGIT) ? M_NUMBER : M_ID;
            tso_d  = pos_q;
            tlen_d = off_t'(1);
            tsl_d  = line_q;
            tsc_d  = col_q;
            pos_d  = pos_inc;
            col_d  = col_inc;
            if (eos) begin
              b_v    = 1'b1;
              res_b  = make_tok((cls == CLS_DIGIT) ? KIND_NUMBER : KIND_ID,
                                pos_q, off_t'(1), line_q, col_q, ERR_NONE);
              mode_d = M_IDLE;
            end
          end
          CLS_MINUS: begin
            b_v    = 1'b1;
            res_b  = make_tok(KIND_NEWLINE, pos_q, '0, line_q, col_q, ERR_MINUS);
            halt_d = 1'b1;
          end
          default: begin
            b_v    = 1'b1;
            res_b  = make_tok(KIND_NEWLINE, pos_q, '0, line_q, col_q, ERR_UNKNOWN_BYTE);
            halt_d = 1'b1;
          end
        endcase
      end
    end

    // The final byte returns everything to the start of a new text.
    if (eos) begin
      mode_d = M_IDLE;
      pos_d  = '0;
      line_d = pos_t'(1);
      col_d  = pos_t'(1);
      tso_d  = '0;
      tlen_d = '0;
      tsl_d  = pos_t'(1);
      tsc_d  = pos_t'(1);
      halt_d = 1'b0;
    end
  end

  always_comb begin
    res0             = a_v ? res_a : res_b;
    res0.last_result = ~(a_v & b_v);
    res1             = res_b;
    res1.last_result = 1'b1;
  end

  assign slot_free   = ~out_valid_q | ~out_stall_i;
  assign pop_o       = ~pend_valid_q & q_valid_i & slot_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      pos_q        <= '0;
      line_q       <= pos_t'(1);
      col_q        <= pos_t'(1);
      tso_q        <= '0;
      tlen_q       <= '0;
      tsl_q        <= pos_t'(1);
      tsc_q        <= pos_t'(1);
      halt_q       <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
    end else if (pend_valid_q) begin
      if (slot_free) begin
        out_q        <= pend_q;
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end
    end else if (pop_o) begin
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      line_q       <= line_d;
      col_q        <= col_d;
      tso_q        <= tso_d;
      tlen_q       <= tlen_d;
      tsl_q        <= tsl_d;
      tsc_q        <= tsc_d;
      halt_q       <= halt_d;
      out_q        <= res0;
      out_valid_q  <= a_v | b_v;
      pend_q       <= res1;
      pend_valid_q <= a_v & b_v;
    end else if (slot_free) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/assembly_source_tokenizer.sv
// Top level of the assembly source tokenizer: front, byte queue and lexer.
//
// Feed the source text one byte per transaction on the input channel and
// set end_of_source on the final byte; the block then flushes any open
// identifier or number and returns to offset 0, line 1, column 1 for the
// next text. Each output transaction is one token (newline, VT/FF/CR
// space, preprocess, comma, colon, identifier, string, number or char)
// or one error; last_result marks the final result caused by a byte.
// Space, tab and semicolon comments give nothing. After an error the
// block drops bytes until end_of_source. The front classifies each byte
// and writes it into a four-entry queue; the lexer pops one entry per
// cycle while no result is held back, updates its state and loads a
// registered output stage, so with no output stall the block takes one
// byte every cycle. A byte that closes an identifier or number and
// also starts a token of its own yields two results: the second waits
// in a one-entry hold register and the lexer pauses while it drains,
// which the queue absorbs. Offsets and lengths are 20 bits and line and
// column 16 bits, all saturating. There is no clearing pass after reset.
module assembly_source_tokenizer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  asmtok_pkg::src_item_t in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output asmtok_pkg::tok_item_t out_data_o,
  input  logic                  out_stall_i
);
  import asmtok_pkg::*;

  logic       push;
  cls_entry_t push_data;
  logic       full;
  logic       pop;
  logic       q_valid;
  cls_entry_t q_data;

  // Classify and push accepted bytes; stall the source when the queue is full.
  asmtok_front u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Decouple byte intake from token output stalls.
  asmtok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data)
  );

  // Advance the lexer state one byte per pop and hold results for the sink.
  asmtok_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: hw/rtl/asmtok_checker.sv
// Port-level assertion checker for the tokenizer and its bind statement.
`include "assembly_source_tokenizer_assert.svh"

module asmtok_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input asmtok_pkg::tok_item_t out_data_o,
  input logic                  out_stall_i
);
  import asmtok_pkg::*;

  `ASMTOK_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled token changed")
  `ASMTOK_ASSERT_NOW(a_err_shape, out_valid_o && out_data_o.error_code != ERR_NONE, out_data_o.token_kind == KIND_NEWLINE && out_data_o.text_length == '0, "error result has kind or length set")
  `ASMTOK_ASSERT_NOW(a_err_last, out_valid_o && out_data_o.error_code != ERR_NONE, out_data_o.last_result, "error result not last of its byte")
  `ASMTOK_ASSERT_NOW(a_pos_nonzero, out_valid_o, out_data_o.token_line != '0 && out_data_o.token_column != '0, "line or column is zero")

endmodule

bind assembly_source_tokenizer asmtok_checker u_asmtok_checker (.*);
